[design/hybrid_run_merge_sorter_macros.svh]
// Assertion macros used by the sorter checker.
`ifndef HYBRID_RUN_MERGE_SORTER_MACROS_SVH
`define HYBRID_RUN_MERGE_SORTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HRMS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorter check failed in the same cycle");

// Next-cycle implication, disabled during reset.
`define HRMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorter check failed one cycle later");

`endif

[design/hrms_pkg.sv]
// ----------------------------------------------------------------------------
// hrms_pkg: shared types and constants of the run-merge sorter
// Element width, default depth and the structs passed between sorter cells.
// ----------------------------------------------------------------------------
package hrms_pkg;

   localparam int HRMS_VALUE_WIDTH = 32;
   localparam int HRMS_MAX_ELEMENTS = 64;

   typedef logic signed [HRMS_VALUE_WIDTH-1:0] hrms_value_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic           occ;   // cell holds an element
      logic           le;    // held element <= insert key
      hrms_value_type val;   // held element
   } hrms_link_type;

   // command broadcast to every cell
   typedef struct packed {
      logic           insert;  // place key into the sorted row
      logic           shift;   // move the row one cell toward the head
      hrms_value_type key;     // element being inserted
   } hrms_ctrl_type;

endpackage

[design/hrms_if.sv]
// ----------------------------------------------------------------------------
// hrms_req_if / hrms_rsp_if: valid-ready channels of the sorter
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface hrms_req_if
   import hrms_pkg::*;
   ();
   logic           valid;
   logic           ready;
   hrms_value_type value;
   logic           last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface hrms_rsp_if
   import hrms_pkg::*;
   ();
   logic           valid;
   logic           ready;
   hrms_value_type sorted_value;
   logic           end_of_set;
   logic           overflow;

   modport source (output valid, output sorted_value, output end_of_set,
                   output overflow, input ready);
   modport sink (input valid, input sorted_value, input end_of_set,
                 input overflow, output ready);
endinterface

[design/hrms_cell.sv]
// ----------------------------------------------------------------------------
// hrms_cell: one slot of the systolic insertion row
// Holds one element; on insert it keeps, takes the key or takes its left
// neighbor's element; on drain it takes its right neighbor's element.
// ----------------------------------------------------------------------------
module hrms_cell
   import hrms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  hrms_ctrl_type ctrl,
   input  hrms_link_type left_link,
   input  hrms_link_type right_link,
   output hrms_link_type link
);

   logic           occ_ff, occ_in;
   hrms_value_type val_ff, val_in;
   logic           le;

   // held element stays in front of the key
   assign le = occ_ff && (val_ff <= ctrl.key);
   assign link = '{occ: occ_ff, le: le, val: val_ff};

   // next contents
   always_comb begin
      occ_in = occ_ff;
      val_in = val_ff;
      if (ctrl.insert) begin
         if (!le) begin
            occ_in = occ_ff | left_link.occ;
            val_in = left_link.le ? ctrl.key : left_link.val;
         end
      end else if (ctrl.shift) begin
         occ_in = right_link.occ;
         val_in = right_link.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      val_ff <= val_in;
   end

endmodule

[design/hybrid_run_merge_sorter.sv]
// Load: a set of n elements loads one element per taken beat; the first
// sorted beat is offered the cycle after the last-marked beat is taken.
// Flow: each taken input beat inserts its element unless the row is full,
// each taken output beat emits one, by the row's single insert/shift step.
// Reset: synchronous, clears all occupancy, the overflow flag and drain mode.
// ----------------------------------------------------------------------------
// hybrid_run_merge_sorter: sorts a set of signed values ascending
// A row of cells keeps the buffered elements in order as they arrive; the
// row then drains through its head cell, marking the last element.
// ----------------------------------------------------------------------------
module hybrid_run_merge_sorter
   import hrms_pkg::*;
#(
   parameter int MAX_ELEMENTS = HRMS_MAX_ELEMENTS
)
(
   input  logic       clock,
   input  logic       reset,
   hrms_req_if.sink   req,
   hrms_rsp_if.source rsp
);

   hrms_link_type cell_link [MAX_ELEMENTS];
   hrms_ctrl_type ctrl;
   logic          drain_ff, drain_in;
   logic          dropped_ff, dropped_in;
   logic          req_beat, rsp_beat, full, final_beat;

   // handshakes
   assign req.ready  = !drain_ff;
   assign req_beat   = req.valid && req.ready;
   assign rsp_beat   = rsp.valid && rsp.ready;
   assign full       = cell_link[MAX_ELEMENTS-1].occ;
   assign final_beat = rsp_beat && rsp.end_of_set;

   // cell commands
   assign ctrl = '{insert: req_beat && !full, shift: rsp_beat, key: req.value};

   // cell row
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      hrms_link_type left_l, right_l;
      if (i == 0) begin : g_head
         assign left_l = '{occ: 1'b1, le: 1'b1, val: '0};
      end else begin : g_body
         assign left_l = cell_link[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_tail
         assign right_l = '{occ: 1'b0, le: 1'b0, val: '0};
      end else begin : g_inner
         assign right_l = cell_link[i+1];
      end
      hrms_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_link  (left_l),
         .right_link (right_l),
         .link       (cell_link[i])
      );
   end

   // drain mode and overflow flag
   always_comb begin
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (req_beat) begin
         if (full) begin
            dropped_in = 1'b1;
         end
         if (req.last) begin
            drain_in = 1'b1;
         end
      end
      if (final_beat) begin
         drain_in   = 1'b0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         drain_ff   <= drain_in;
         dropped_ff <= dropped_in;
      end
   end

   // result beat straight from the head cell
   assign rsp.valid        = drain_ff;
   assign rsp.sorted_value = cell_link[0].val;
   assign rsp.end_of_set   = !cell_link[1].occ;
   assign rsp.overflow     = dropped_ff;

endmodule

[design/hrms_checker.sv]
// ----------------------------------------------------------------------------
// hrms_checker: port-level checks of the run-merge sorter
// Watches the load/drain alternation and the per-set overflow flag.
// ----------------------------------------------------------------------------
`include "hybrid_run_merge_sorter_macros.svh"

module hrms_checker
   import hrms_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_end_of_set,
   input logic rsp_overflow
);

   logic req_beat, rsp_beat, rsp_final, rsp_open;
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;
   assign rsp_final = rsp_beat && rsp_end_of_set;
   // drain in progress and not ending this cycle
   assign rsp_open  = rsp_valid && !rsp_final;

   // no loading while a set drains
   `HRMS_ASSERT_SAME(a_no_load_in_drain, clock, reset, rsp_valid, !req_ready)
   // a last-marked beat starts the drain
   `HRMS_ASSERT_NEXT(a_last_starts_drain, clock, reset, req_beat && req_last, rsp_valid)
   // the final element ends the drain and reopens the input
   `HRMS_ASSERT_NEXT(a_end_closes_drain, clock, reset, rsp_final, !rsp_valid && req_ready)
   // overflow holds steady while a set drains
   `HRMS_ASSERT_NEXT(a_overflow_steady, clock, reset, rsp_open, $stable(rsp_overflow))

endmodule

bind hybrid_run_merge_sorter hrms_checker u_hrms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_last       (req.last),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_end_of_set (rsp.end_of_set),
   .rsp_overflow   (rsp.overflow)
);
